### design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, constants and helpers for the 3x3 Laplacian sharpen stream.
// ----------------------------------------------------------------------------
package lss_pkg;

  // Line store depth (largest frame width supported).
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Field widths.
  localparam int PIX_W = 8;
  localparam int ROW_W = 16;
  localparam int COL_W = 10;
  localparam int FW_W  = 11;
  localparam int FH_W  = 16;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result slots a pixel may cause, in delivery order.
  localparam int EMIT_INNER  = 0;  // (r-1, c-1), filtered or border
  localparam int EMIT_EDGE   = 1;  // (r-1, c), right border
  localparam int EMIT_BOTTOM = 2;  // (r, c), bottom border
  localparam int EMIT_N      = 3;

  // Decoded job: one accepted pixel and the results it causes.
  typedef struct packed {
    logic [EMIT_N-1:0] emit_mask;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  value;
  } job_t;

  // Queue status toward the front.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_stat_t;

  // Clamp a 12-bit signed filter sum to 0..255.
  function automatic logic [PIX_W-1:0] sat_u8(input logic signed [11:0] v);
    logic [PIX_W-1:0] r;
    if (v[11]) begin
      r = '0;
    end else if (|v[10:8]) begin
      r = '1;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

### design/lss_stream_if.sv
// ----------------------------------------------------------------------------
// lss_pix_if / lss_res_if
// Valid/ready channels for input pixels and sharpened results.
// ----------------------------------------------------------------------------
interface lss_pix_if;
  logic                      valid;
  logic                      ready;
  logic [lss_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lss_res_if;
  logic                      valid;
  logic                      ready;
  logic [lss_pkg::ROW_W-1:0] out_row;
  logic [lss_pkg::COL_W-1:0] out_col;
  logic [lss_pkg::PIX_W-1:0] out_value;
  logic                      run_last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output run_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input run_last, output ready);
endinterface

### design/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lss_front.sv
// ----------------------------------------------------------------------------
// lss_front
// Accepts pixels, tracks row/column, reads the line stores, applies the
// 3x3 kernel and pushes one decoded job per pixel that causes results.
// ----------------------------------------------------------------------------
module lss_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lss_pkg::CFG_W-1:0]     cfg_data,
  lss_pix_if.sink                       pix,
  input  lss_pkg::q_stat_t              q_stat,
  output logic                          push,
  output lss_pkg::job_t                 push_job
);

  localparam int PW = lss_pkg::PIX_W;

  logic [lss_pkg::FW_W-1:0]  frame_width;
  logic [lss_pkg::FH_W-1:0]  frame_height;
  logic [lss_pkg::ROW_W-1:0] row_count;
  logic [lss_pkg::COL_W-1:0] col_count;

  logic [lss_pkg::FW_W-1:0]  w_eff;
  logic [lss_pkg::FH_W-1:0]  h_eff;
  logic [lss_pkg::FW_W-1:0]  col_inc;
  logic [lss_pkg::ROW_W:0]   row_inc;
  logic                      last_col;
  logic                      last_row;
  logic                      interior;
  logic                      accept;
  logic [lss_pkg::EMIT_N-1:0] mask;

  // Stage 1 (line store data valid)
  logic                       s1_valid;
  logic [PW-1:0]              s1_pixel;
  logic [lss_pkg::ROW_W-1:0]  s1_row;
  logic [lss_pkg::COL_W-1:0]  s1_col;
  logic [lss_pkg::EMIT_N-1:0] s1_mask;
  logic                       s1_interior;
  logic                       s1_fwd;
  logic [PW-1:0]              s1_fwd_top;
  logic [PW-1:0]              s1_fwd_mid;

  logic [PW-1:0] ram_top;
  logic [PW-1:0] ram_mid;
  logic [PW-1:0] top;
  logic [PW-1:0] mid;

  // Window: column c-1 (top, mid, bottom) and center of column c-2.
  logic [PW-1:0] win_top;
  logic [PW-1:0] win_mid;
  logic [PW-1:0] win_bot;
  logic [PW-1:0] win_left;

  logic [11:0]        gain;
  logic [11:0]        negs;
  logic signed [11:0] acc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lss_pkg::FRAME_WIDTH_RESET;
      frame_height <= lss_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lss_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[lss_pkg::FW_W-1:0];
        lss_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[lss_pkg::FH_W-1:0];
      endcase
    end
  end

  // Stage 0: classify the incoming pixel
  always_comb begin
    if (frame_width == '0) begin
      w_eff = lss_pkg::FW_W'(1);
    end else if (frame_width > lss_pkg::FW_W'(lss_pkg::MAX_WIDTH)) begin
      w_eff = lss_pkg::FW_W'(lss_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff    = (frame_height == '0) ? lss_pkg::FH_W'(1) : frame_height;
    col_inc  = {1'b0, col_count} + lss_pkg::FW_W'(1);
    row_inc  = {1'b0, row_count} + (lss_pkg::ROW_W + 1)'(1);
    last_col = col_inc >= w_eff;
    last_row = row_inc >= {1'b0, h_eff};
    interior = (row_count >= lss_pkg::ROW_W'(2)) && (row_inc <= {1'b0, h_eff}) &&
               (col_count >= lss_pkg::COL_W'(2)) && (col_inc <= w_eff);
    mask = '0;
    mask[lss_pkg::EMIT_INNER]  = (row_count != '0) && (col_count != '0);
    mask[lss_pkg::EMIT_EDGE]   = last_col && (row_count != '0);
    mask[lss_pkg::EMIT_BOTTOM] = last_row;
  end

  // Stage 1 never stalls, so keep room in the queue for what is in flight.
  assign pix.ready = ({1'b0, q_stat.count} + {{lss_pkg::QCNT_W{1'b0}}, s1_valid})
                     < (lss_pkg::QCNT_W + 1)'(lss_pkg::QDEPTH);
  assign accept = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_inc[lss_pkg::ROW_W-1:0];
      end else begin
        col_count <= col_inc[lss_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pix.pixel;
      s1_row      <= row_count;
      s1_col      <= col_count;
      s1_mask     <= mask;
      s1_interior <= interior;
      // same column written this cycle (one-pixel-wide frames)
      s1_fwd      <= s1_valid && (s1_col == col_count);
      s1_fwd_top  <= mid;
      s1_fwd_mid  <= s1_pixel;
    end
  end

  lss_ram #(.WIDTH(PW), .DEPTH(lss_pkg::MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col[lss_pkg::ADDR_W-1:0]),
    .wdata (mid),
    .re    (accept),
    .raddr (col_count[lss_pkg::ADDR_W-1:0]),
    .rdata (ram_top)
  );

  lss_ram #(.WIDTH(PW), .DEPTH(lss_pkg::MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col[lss_pkg::ADDR_W-1:0]),
    .wdata (s1_pixel),
    .re    (accept),
    .raddr (col_count[lss_pkg::ADDR_W-1:0]),
    .rdata (ram_mid)
  );

  // Stage 1: kernel 5*center - up - down - left - right
  always_comb begin
    top  = s1_fwd ? s1_fwd_top : ram_top;
    mid  = s1_fwd ? s1_fwd_mid : ram_mid;
    gain = {2'b00, win_mid, 2'b00} + {4'b0000, win_mid};
    negs = {4'b0000, win_top} + {4'b0000, win_bot} + {4'b0000, win_left} +
           {4'b0000, mid};
    acc  = signed'(gain - negs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_top  <= '0;
      win_mid  <= '0;
      win_bot  <= '0;
      win_left <= '0;
    end else if (s1_valid) begin
      win_left <= win_mid;
      win_top  <= top;
      win_mid  <= mid;
      win_bot  <= s1_pixel;
    end
  end

  assign push               = s1_valid && (s1_mask != '0);
  assign push_job.emit_mask = s1_mask;
  assign push_job.row       = s1_row;
  assign push_job.col       = s1_col;
  assign push_job.value     = s1_interior ? lss_pkg::sat_u8(acc) : '0;

endmodule

### design/lss_queue.sv
// ----------------------------------------------------------------------------
// lss_queue
// Small register FIFO of decoded jobs between front and back.
// ----------------------------------------------------------------------------
module lss_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lss_pkg::job_t    push_job,
  input  logic             pop,
  output lss_pkg::job_t    head,
  output lss_pkg::q_stat_t stat
);

  lss_pkg::job_t                entries [lss_pkg::QDEPTH];
  logic [lss_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lss_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lss_pkg::QCNT_W-1:0]   count;
  logic                         do_pop;

  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lss_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + lss_pkg::QPTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + lss_pkg::QCNT_W'(1);
        2'b01:   count <= count - lss_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

endmodule

### design/lss_back.sv
// ----------------------------------------------------------------------------
// lss_back
// Expands each job into its one to three results and drives the output
// register, one transaction per cycle while results are taken.
// ----------------------------------------------------------------------------
module lss_back (
  input  logic             clk,
  input  logic             rst,
  input  lss_pkg::job_t    head,
  input  lss_pkg::q_stat_t q_stat,
  output logic             pop,
  lss_res_if.source        res
);

  lss_pkg::job_t              cur;
  logic [lss_pkg::EMIT_N-1:0] mask;
  logic [lss_pkg::EMIT_N-1:0] mask_next;
  logic                       out_valid;
  logic                       load;
  logic                       emit;
  logic                       take;
  logic [lss_pkg::ROW_W-1:0]  sel_row;
  logic [lss_pkg::COL_W-1:0]  sel_col;
  logic [lss_pkg::PIX_W-1:0]  sel_value;

  always_comb begin
    load = !out_valid || res.ready;
    emit = load && (mask != '0);
    mask_next = mask;
    sel_row   = cur.row;
    sel_col   = cur.col;
    sel_value = '0;
    if (mask[lss_pkg::EMIT_INNER]) begin
      sel_row   = cur.row - lss_pkg::ROW_W'(1);
      sel_col   = cur.col - lss_pkg::COL_W'(1);
      sel_value = cur.value;
      mask_next[lss_pkg::EMIT_INNER] = 1'b0;
    end else if (mask[lss_pkg::EMIT_EDGE]) begin
      sel_row = cur.row - lss_pkg::ROW_W'(1);
      mask_next[lss_pkg::EMIT_EDGE] = 1'b0;
    end else begin
      mask_next = '0;
    end
    take = !q_stat.empty && ((mask == '0) || (emit && (mask_next == '0)));
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (take) begin
      mask <= head.emit_mask;
    end else if (emit) begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.out_row   <= sel_row;
      res.out_col   <= sel_col;
      res.out_value <= sel_value;
      res.run_last  <= (mask_next == '0);
    end
  end

  assign res.valid = out_valid;

endmodule

### design/laplacian_sharpen_3x3_stream_top.sv
// Path: an accepted pixel passes the kernel stage, the job queue and the
//   expansion register before its results leave the output register.
// Throughput: one pixel per cycle while results are taken and each pixel
//   causes at most one result; a last-column or last-row pixel sends more.
// Reset (rst, synchronous): counters, window and queue cleared, frame size
//   back to 640x480; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_stream_top
// 3x3 Laplacian sharpen of a raster pixel stream with row/column tagging.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_stream_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lss_pkg::CFG_W-1:0]     cfg_data,
  lss_pix_if.sink                       pix,
  lss_res_if.source                     res
);

  // Front: counters, line stores, kernel. One decoded job per pixel that
  // produces any result; pixels of row 0 (not the last row) produce none.
  // Ready is held low only when the job queue could overflow.
  logic             push;
  lss_pkg::job_t    push_job;
  lss_pkg::job_t    head;
  lss_pkg::q_stat_t q_stat;
  logic             pop;

  lss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Queue decouples the pixel side from result backpressure.
  lss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Back: emits inner, right-border and bottom-border results in that order,
  // run_last on the final one of each job. The output register lets the
  // next job load while a result waits to be taken.
  lss_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .res    (res)
  );

endmodule

### design/lss_checker.sv
// ----------------------------------------------------------------------------
// lss_checker
// Port-level checks on the sharpen stream, bound to the top level.
// ----------------------------------------------------------------------------
module lss_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [lss_pkg::ROW_W-1:0] out_row,
  input logic [lss_pkg::COL_W-1:0] out_col,
  input logic [lss_pkg::PIX_W-1:0] out_value,
  input logic                      run_last
);

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Top and left border pixels are always zero.
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_value != '0 |-> out_row != '0 && out_col != '0)
    else $error("nonzero value on top or left border");

  // A stalled result keeps its payload until taken.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable({out_row, out_col, out_value, run_last}))
    else $error("result changed while stalled");

endmodule

bind laplacian_sharpen_3x3_stream_top lss_checker u_lss_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .out_row   (res.out_row),
  .out_col   (res.out_col),
  .out_value (res.out_value),
  .run_last  (res.run_last)
);

### verif/laplacian_sharpen_3x3_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_stream_checker
// Watches the pixel, result and config ports, predicts every tagged result of
// the sharpen filter and compares it in order with what the block delivers.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_stream_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lss_pkg::CFG_W-1:0]     cfg_data,
  lss_pix_if                            pix,
  lss_res_if                            res,
  output int                            pending,
  output int                            fail_count
);

  localparam int CENTER_GAIN = 5;

  typedef struct packed {
    logic [lss_pkg::ROW_W-1:0] row;
    logic [lss_pkg::COL_W-1:0] col;
    logic [lss_pkg::PIX_W-1:0] value;
    logic                      run_last;
  } out_pixel_t;

  logic [lss_pkg::FW_W-1:0]  width_reg;
  logic [lss_pkg::FH_W-1:0]  height_reg;
  logic [lss_pkg::PIX_W-1:0] row_prev  [lss_pkg::MAX_WIDTH];
  logic [lss_pkg::PIX_W-1:0] row_prev2 [lss_pkg::MAX_WIDTH];
  logic [lss_pkg::PIX_W-1:0] win [6];  // [0..2] column c-1 top/mid/bot, [3..5] column c-2
  logic [lss_pkg::ROW_W-1:0] cur_row;
  logic [lss_pkg::COL_W-1:0] cur_col;

  out_pixel_t sharpened_q[$];
  out_pixel_t got, want;

  function automatic string describe(input out_pixel_t p);
    return $sformatf("(row %0d, col %0d) = %0d last %0b", p.row, p.col, p.value, p.run_last);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // One accepted pixel: queue the results it causes, then advance the state.
  task automatic sharpen_step(input logic [lss_pkg::PIX_W-1:0] px);
    int w, h, r, c, v, n;
    logic [lss_pkg::PIX_W-1:0] up_px, mid_px;
    bit last_col, last_row;
    out_pixel_t batch [3];

    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > lss_pkg::MAX_WIDTH) w = lss_pkg::MAX_WIDTH;
    h = int'(height_reg);
    if (h < 1) h = 1;
    r = int'(cur_row);
    c = int'(cur_col);
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    up_px  = row_prev2[c];
    mid_px = row_prev[c];
    n = 0;

    if (r >= 1 && c >= 1) begin
      v = 0;
      if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w) begin
        v = CENTER_GAIN * int'(win[1]) - int'(win[0]) - int'(win[2])
            - int'(win[4]) - int'(mid_px);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      batch[n].row      = lss_pkg::ROW_W'(r - 1);
      batch[n].col      = lss_pkg::COL_W'(c - 1);
      batch[n].value    = lss_pkg::PIX_W'(v);
      batch[n].run_last = 1'b0;
      n++;
    end
    // right border of the row above
    if (last_col && r >= 1) begin
      batch[n].row      = lss_pkg::ROW_W'(r - 1);
      batch[n].col      = lss_pkg::COL_W'(c);
      batch[n].value    = '0;
      batch[n].run_last = 1'b0;
      n++;
    end
    // bottom border
    if (last_row) begin
      batch[n].row      = lss_pkg::ROW_W'(r);
      batch[n].col      = lss_pkg::COL_W'(c);
      batch[n].value    = '0;
      batch[n].run_last = 1'b0;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      batch[i].run_last = (i == n - 1);
      sharpened_q.push_back(batch[i]);
    end

    row_prev2[c] = mid_px;
    row_prev[c]  = px;
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = up_px;
    win[1] = mid_px;
    win[2] = px;

    if (last_col) begin
      cur_col = '0;
      cur_row = last_row ? '0 : lss_pkg::ROW_W'(r + 1);
    end else begin
      cur_col = lss_pkg::COL_W'(c + 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = lss_pkg::FRAME_WIDTH_RESET;
      height_reg = lss_pkg::FRAME_HEIGHT_RESET;
      cur_row    = '0;
      cur_col    = '0;
      fail_count = 0;
      for (int i = 0; i < 6; i++) win[i] = '0;
      for (int i = 0; i < lss_pkg::MAX_WIDTH; i++) begin
        row_prev[i]  = '0;
        row_prev2[i] = '0;
      end
      sharpened_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == lss_pkg::REG_FRAME_WIDTH) begin
          width_reg = cfg_data[lss_pkg::FW_W-1:0];
        end else if (cfg_index == lss_pkg::REG_FRAME_HEIGHT) begin
          height_reg = cfg_data[lss_pkg::FH_W-1:0];
        end
      end
      if (res.valid && res.ready) begin
        got = '{res.out_row, res.out_col, res.out_value, res.run_last};
        if (sharpened_q.size() == 0) begin
          note_failure({"result with nothing outstanding: ", describe(got)});
        end else begin
          want = sharpened_q.pop_front();
          if (got !== want)
            note_failure({"expected ", describe(want), ", got ", describe(got)});
        end
      end
      if (pix.valid && pix.ready) sharpen_step(pix.pixel);
    end
    pending <= sharpened_q.size();
  end

endmodule

### verif/laplacian_sharpen_3x3_stream_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_stream_top_test
// Drives pixel frames of many sizes into the sharpen filter under random
// back-pressure and input gaps; the checker beside the block predicts every
// tagged result and this module reports the verdict.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_stream_top_test;

  // Cycles to let pass after the last result before touching config: covers
  // the pipeline when the last pixel caused no result.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no transaction on any port before the run is declared hung.
  localparam int QUIET_LIMIT   = 1000;

  logic clk = 1'b0;
  logic rst;
  logic                          cfg_we;
  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lss_pkg::CFG_W-1:0]     cfg_data;

  lss_pix_if pix_ch ();
  lss_res_if res_ch ();

  int pending;
  int fail_count;

  // Stimulus knobs.
  bit  gappy;          // sender inserts idle bursts
  logic calm = 1'b0;   // last stretch: no stalls on either side
  int  frame_w, frame_h;
  int  ready_hold;
  int  quiet_cycles;
  int  random_sent;
  int  n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  laplacian_sharpen_3x3_stream_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch),
    .res       (res_ch)
  );

  laplacian_sharpen_3x3_stream_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix        (pix_ch),
    .res        (res_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Result side: ready alternates between random stall bursts and open
  // stretches; held high through reset and the final calm stretch.
  always @(posedge clk) begin
    if (rst || calm) begin
      res_ch.ready <= 1'b1;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (res_ch.ready && $urandom_range(0, 2) == 0) begin
      res_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 14);
    end else begin
      res_ch.ready <= 1'b1;
      ready_hold   <= ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 40);
    end
  end

  // Hang detector: any transaction on any port resets the count.
  always @(posedge clk) begin
    if (rst || cfg_we || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Biased toward the rails so saturation happens both ways.
  function automatic logic [lss_pkg::PIX_W-1:0] random_pixel();
    logic [lss_pkg::PIX_W-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = '1;
      default: v = lss_pkg::PIX_W'($urandom);
    endcase
    return v;
  endfunction

  // One pixel transaction. With gaps on, the sender sometimes idles for a
  // burst and now and then holds off until every pending result is out.
  task automatic feed_pixel(input logic [lss_pkg::PIX_W-1:0] value);
    if (gappy && $urandom_range(0, 49) == 0) begin
      pix_ch.valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end else if (gappy && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= value;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) feed_pixel(random_pixel());
  endtask

  // Stop sending, let all results out and the pipeline empty.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both frame registers while the block is idle and keep the
  // effective frame size for whole-frame stimulus.
  task automatic set_frame(input logic [lss_pkg::CFG_W-1:0] wdata,
                           input logic [lss_pkg::CFG_W-1:0] hdata);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= lss_pkg::REG_FRAME_WIDTH;
    cfg_data  <= wdata;
    @(posedge clk);
    cfg_index <= lss_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= hdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_w = int'(wdata[lss_pkg::FW_W-1:0]);
    if (frame_w == 0) frame_w = 1;
    if (frame_w > lss_pkg::MAX_WIDTH) frame_w = lss_pkg::MAX_WIDTH;
    frame_h = (hdata[lss_pkg::FH_W-1:0] == 0) ? 1 : int'(hdata[lss_pkg::FH_W-1:0]);
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= lss_pkg::REG_FRAME_WIDTH;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    gappy        = 1'b1;
    random_sent  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- Directed ---------------------------------------------------------
    // Default 640x480: a few pixels of row 0 only, none of them cause results.
    feed_pixel(8'h00);
    feed_pixel(8'hFF);
    feed_pixel(8'h00);
    feed_pixel(8'hFF);
    feed_pixel(8'h55);
    feed_pixel(8'hAA);
    feed_pixel(8'h01);
    feed_pixel(8'h80);

    // Shrink to 5x4 mid-row, junk in the unused width bits: column 8 is past
    // the end and must be taken as the last column.
    set_frame(16'hF805, 16'd4);
    feed_pixel(8'hFF);
    // Checkerboard: bright centers clip high, dark centers clip at zero.
    for (int r = 1; r < 4; r++)
      for (int c = 0; c < 5; c++)
        feed_pixel(((r + c) % 2) ? 8'hFF : 8'h00);

    // --- Tiny and degenerate frames (all border) ---------------------------
    set_frame(16'd3, 16'd1);
    send_pixels(2 * frame_w * frame_h);
    set_frame(16'd4, 16'd2);
    send_pixels(frame_w * frame_h);
    set_frame(16'd3, 16'd0);     // height zero acts as one row
    send_pixels(frame_w * frame_h);
    set_frame(16'd2, 16'd5);
    send_pixels(frame_w * frame_h);
    set_frame(16'd1, 16'd3);
    send_pixels(frame_w * frame_h);
    set_frame(16'd0, 16'd3);     // width zero acts as one column
    send_pixels(frame_w * frame_h);

    // Height shrinks to 2 while on row 3: that row becomes the last row.
    set_frame(16'd6, 16'd10);
    send_pixels(20);
    set_frame(16'd6, 16'd2);
    send_pixels(4);

    // Width shrinks to 3 at column 4 of row 1: finish the row, then the frame.
    set_frame(16'd9, 16'd6);
    send_pixels(13);
    set_frame(16'd3, 16'd6);
    send_pixels(13);

    // --- Random frames ----------------------------------------------------
    while (random_sent < 100) begin
      gappy = ($urandom_range(0, 2) != 0);
      set_frame({5'($urandom), 11'($urandom_range(3, 12))}, 16'($urandom_range(3, 6)));
      n = frame_w * frame_h;
      send_pixels(n);
      random_sent += n;
    end

    // --- Last stretch: no stalls on either side ---------------------------
    set_frame(16'd7, 16'd4);
    calm  <= 1'b1;
    gappy = 1'b0;
    send_pixels(frame_w * frame_h);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
